// ----- hw/rtl/scr_pkg.sv -----
// Shared types, codes and CRC-16/ARC helpers for the SLIP/CRC frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package scr_pkg;

  // SLIP special bytes
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // default geometry
  localparam int FRAME_MAX_DEF  = 256;
  localparam int BANK_DEPTH_DEF = 512;
  localparam int MIN_FRAME_DEF  = 4;
  localparam int BANK_DEPTH_MAX = 8192;
  localparam int POS_W          = $clog2(BANK_DEPTH_MAX);

  // fixed port field widths
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int LEN_PORT_W  = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_LINE    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE  = 3'd0,
    ST_OK    = 3'd1,
    ST_SHORT = 3'd2,
    ST_CRC   = 3'd3,
    ST_BUSY  = 3'd4,
    ST_LONG  = 3'd5
  } status_t;

  // one write into the frame store
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } mem_wr_t;

  // one read from the frame store
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [POS_W-1:0] pos;
  } mem_rd_t;

  // per-beat result fields known at accept time
  typedef struct packed {
    status_t               status;
    logic                  ready;
    logic [LEN_PORT_W-1:0] len;
    logic                  hit;   // read_data comes from the store
    logic                  sel;   // odd half of the store
  } res_meta_t;

  // CRC-16/ARC byte table entry (reflected poly 0xA001)
  function automatic logic [15:0] crc_tab(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    return {8'h00, crc[15:8]} ^ crc_tab(crc[7:0] ^ b);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scr_frame_store.sv -----
// Two-bank frame byte store, split into even and odd byte memories so a
// beat can write two consecutive bytes. Depends on scr_pkg.
`default_nettype none

module scr_frame_store #(
  parameter int BANK_DEPTH = scr_pkg::BANK_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire scr_pkg::mem_wr_t wr0,
  input  wire scr_pkg::mem_wr_t wr1,
  input  wire scr_pkg::mem_rd_t rd,
  output logic [7:0]            even_q,
  output logic [7:0]            odd_q
);
  import scr_pkg::*;

  localparam int HALF  = (BANK_DEPTH + 1) / 2;
  localparam int DEPTH = 2 * HALF;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0] mem_even [DEPTH];
  logic [7:0] mem_odd  [DEPTH];

  mem_wr_t we_even, we_odd;
  logic [AW-1:0] ea, oa, ra;

  function automatic logic [AW-1:0] word_addr(input logic bank, input logic [POS_W-1:0] pos);
    return AW'((bank ? 32'(HALF) : 32'd0) + (32'(pos) >> 1));
  endfunction

  // two writes of one beat always land in different halves
  always_comb begin
    we_even = '0;
    we_odd  = '0;
    if (wr0.en && !wr0.pos[0]) we_even = wr0;
    else if (wr1.en && !wr1.pos[0]) we_even = wr1;
    if (wr0.en && wr0.pos[0]) we_odd = wr0;
    else if (wr1.en && wr1.pos[0]) we_odd = wr1;
  end

  assign ea = word_addr(we_even.bank, we_even.pos);
  assign oa = word_addr(we_odd.bank, we_odd.pos);
  assign ra = word_addr(rd.bank, rd.pos);

  always_ff @(posedge clk) begin
    if (we_even.en) mem_even[ea] <= we_even.data;
    if (we_odd.en) mem_odd[oa] <= we_odd.data;
    if (rd.en) begin
      even_q <= mem_even[ra];
      odd_q  <= mem_odd[ra];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scr_deframer.sv -----
// SLIP decoder, running CRC, frame checks and held-frame bookkeeping.
// Issues store writes/reads and the result fields of each beat. Depends on scr_pkg.
`default_nettype none

module scr_deframer #(
  parameter int FRAME_MAX  = scr_pkg::FRAME_MAX_DEF,
  parameter int BANK_DEPTH = scr_pkg::BANK_DEPTH_DEF,
  parameter int MIN_FRAME  = scr_pkg::MIN_FRAME_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [1:0]            cmd,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [7:0]            read_index,
  output scr_pkg::mem_wr_t           wr0,
  output scr_pkg::mem_wr_t           wr1,
  output scr_pkg::mem_rd_t           rd,
  output scr_pkg::res_meta_t         meta
);
  import scr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_MAX + 3);
  localparam int LEN_W = $clog2(FRAME_MAX + 1);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(FRAME_MAX + 2);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             ovf;
    logic [15:0]      crc;
    logic [7:0]       ra;
    logic [7:0]       rb;
  } fst_t;

  fst_t             fs_r, fs_nxt, fs0, fs1, fs2;
  logic             esc_r, esc_nxt;
  logic             bank_r, bank_nxt;
  logic             held_r, held_nxt;
  logic [LEN_W-1:0] hlen_r, hlen_nxt;

  logic [1:0] npush;
  logic [7:0] p0, p1;
  logic       can0, can1, is_line, is_end;
  status_t    st;

  function automatic logic can_push(input fst_t s);
    return !s.ovf && (s.cnt < CNT_LIM);
  endfunction

  function automatic fst_t push(input fst_t s, input logic [7:0] b);
    fst_t t;
    t = s;
    if (!can_push(s)) begin
      t.ovf = 1'b1;
    end else begin
      if (s.cnt >= CNT_W'(2)) t.crc = crc_step(s.crc, s.ra);
      t.ra  = s.rb;
      t.rb  = b;
      t.cnt = s.cnt + CNT_W'(1);
    end
    return t;
  endfunction

  // decode: how many bytes this line beat pushes
  always_comb begin
    npush   = 2'd0;
    p0      = rx_byte;
    p1      = rx_byte;
    esc_nxt = esc_r;
    if (esc_r) begin
      esc_nxt = 1'b0;
      npush   = 2'd1;
      if (rx_byte == SLIP_ESC_END) p0 = SLIP_END;
      else if (rx_byte == SLIP_ESC_ESC) p0 = SLIP_ESC;
      else begin
        p0    = SLIP_ESC;
        npush = 2'd2;
      end
    end else if (rx_byte == SLIP_ESC) begin
      esc_nxt = 1'b1;
    end else begin
      npush = 2'd1;
    end
  end

  assign is_line = (cmd_t'(cmd) == CMD_LINE);
  assign is_end  = (rx_byte == SLIP_END);
  assign fs0     = fs_r;
  assign fs1     = (npush != 2'd0) ? push(fs0, p0) : fs0;
  assign fs2     = (npush == 2'd2) ? push(fs1, p1) : fs1;
  assign can0    = can_push(fs0) && (32'(fs0.cnt) < BANK_DEPTH);
  assign can1    = can_push(fs1) && (32'(fs1.cnt) < BANK_DEPTH);

  // frame checks at the end byte: short, long, crc, busy
  always_comb begin
    if (fs_r.cnt == '0 && !fs_r.ovf) st = ST_NONE;
    else if (!fs_r.ovf && fs_r.cnt < CNT_MIN) st = ST_SHORT;
    else if (fs_r.ovf) st = ST_LONG;
    else if ({fs_r.ra, fs_r.rb} != fs_r.crc) st = ST_CRC;
    else if (held_r) st = ST_BUSY;
    else st = ST_OK;
  end

  always_comb begin
    fs_nxt   = fs_r;
    bank_nxt = bank_r;
    held_nxt = held_r;
    hlen_nxt = hlen_r;
    meta     = '0;
    wr0      = '0;
    wr1      = '0;
    rd       = '0;
    meta.status = ST_NONE;
    case (cmd_t'(cmd))
      CMD_LINE: begin
        if (is_end) begin
          meta.status = st;
          fs_nxt      = '0;
          if (st == ST_OK) begin
            held_nxt = 1'b1;
            hlen_nxt = LEN_W'(fs_r.cnt - CNT_W'(2));
            bank_nxt = ~bank_r;
          end
        end else begin
          fs_nxt   = fs2;
          wr0.en   = (npush != 2'd0) && can0;
          wr0.bank = bank_r;
          wr0.pos  = POS_W'(fs0.cnt);
          wr0.data = p0;
          wr1.en   = (npush == 2'd2) && can1;
          wr1.bank = bank_r;
          wr1.pos  = POS_W'(fs1.cnt);
          wr1.data = p1;
        end
      end
      CMD_READ: begin
        meta.hit = held_r && (32'(read_index) < 32'(hlen_r))
                   && (32'(read_index) < BANK_DEPTH);
        meta.sel = read_index[0];
        rd.en    = meta.hit;
        rd.bank  = ~bank_r;
        rd.pos   = POS_W'(read_index);
      end
      CMD_RELEASE: begin
        held_nxt = 1'b0;
        hlen_nxt = '0;
      end
      default: ;
    endcase
    meta.ready = held_nxt;
    meta.len   = held_nxt ? LEN_PORT_W'(hlen_nxt) : '0;
    // gate side effects on the handshake
    wr0.en = wr0.en && accept;
    wr1.en = wr1.en && accept;
    rd.en  = rd.en && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r   <= '0;
      esc_r  <= 1'b0;
      bank_r <= 1'b0;
      held_r <= 1'b0;
      hlen_r <= '0;
    end else if (accept) begin
      fs_r   <= fs_nxt;
      esc_r  <= (is_line && is_end) ? 1'b0 : (is_line ? esc_nxt : esc_r);
      bank_r <= bank_nxt;
      held_r <= held_nxt;
      hlen_r <= hlen_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scr_out_stage.sv -----
// Result pipeline: a stage that waits on the store read, then the output
// register. Drives the ready of the input side. Depends on scr_pkg.
`default_nettype none

module scr_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  output logic                      take,
  input  wire scr_pkg::res_meta_t   meta,
  input  wire logic [7:0]           even_q,
  input  wire logic [7:0]           odd_q,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output scr_pkg::status_t          out_status,
  output logic                      out_frame_ready,
  output logic [scr_pkg::LEN_PORT_W-1:0] out_len,
  output logic [7:0]                out_data
);
  import scr_pkg::*;

  logic      s1_v_r, s1_v_nxt;
  res_meta_t s1_r;
  logic      o_v_r, o_v_nxt;
  logic      adv;

  // s1 drains when the output register is empty or being taken
  assign adv      = !o_v_r || out_ready;
  assign take     = !s1_v_r || adv;
  assign s1_v_nxt = accept || (s1_v_r && !adv);
  assign o_v_nxt  = adv ? s1_v_r : o_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_r <= meta;
    if (adv && s1_v_r) begin
      out_status      <= s1_r.status;
      out_frame_ready <= s1_r.ready;
      out_len         <= s1_r.len;
      out_data        <= s1_r.hit ? (s1_r.sel ? odd_q : even_q) : 8'h00;
    end
  end

  assign out_valid = o_v_r;

endmodule

`default_nettype wire

// ----- hw/rtl/slip_crc_frame_receiver.sv -----
// SLIP frame receiver with CRC-16/ARC check and a two-bank frame store.
// Depends on scr_pkg, scr_deframer, scr_frame_store and scr_out_stage.
//
// Each input beat is a line byte (tuser CMD_LINE), a read of a held byte by
// index (CMD_READ) or a release of the held frame (CMD_RELEASE); each beat
// yields exactly one result beat. Line bytes are SLIP-decoded, checked at
// 0xC0 (short, too long, CRC over all bytes but the last two, busy) and a
// good frame becomes the held frame while filling moves to the other bank.
// The block takes one beat per clock while results drain. With the result
// side stalled it accepts one more beat into the read stage and then holds
// in_tready low until the output register is taken. A result passes the
// read stage, which holds the registered read of the frame store, and then
// the output register. The store is
// two synchronous byte memories holding even and odd positions, so an
// escape byte that expands to two bytes is written in the same cycle. Reads
// only touch the held bank and writes only the fill bank, so no forwarding
// is needed. The store is not cleared after reset: only written bytes are
// ever read, so the block is ready right out of reset.
`default_nettype none

module slip_crc_frame_receiver #(
  parameter int FRAME_MAX  = scr_pkg::FRAME_MAX_DEF,
  parameter int BANK_DEPTH = scr_pkg::BANK_DEPTH_DEF,
  parameter int MIN_FRAME  = scr_pkg::MIN_FRAME_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input beats
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [scr_pkg::IN_TDATA_W-1:0]   in_tdata,   // rx_byte[7:0], read_index[15:8]
  input  wire logic [scr_pkg::CMD_W-1:0]        in_tuser,   // cmd[1:0]
  // result beats
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [scr_pkg::OUT_TDATA_W-1:0]       out_tdata,  // frame_ready[0], frame_length[9:1],
                                                            // read_data[17:10], zero[23:18]
  output logic [scr_pkg::STATUS_W-1:0]          out_tuser   // status[2:0]
);
  import scr_pkg::*;

  logic      accept, take;
  mem_wr_t   wr0, wr1;
  mem_rd_t   rd;
  res_meta_t meta;
  logic [7:0] even_q, odd_q;
  status_t   o_status;
  logic      o_ready;
  logic [LEN_PORT_W-1:0] o_len;
  logic [7:0] o_data;

  assign in_tready = take;
  assign accept    = in_tvalid && take;

  scr_deframer #(
    .FRAME_MAX  (FRAME_MAX),
    .BANK_DEPTH (BANK_DEPTH),
    .MIN_FRAME  (MIN_FRAME)
  ) u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (in_tuser),
    .rx_byte    (in_tdata[7:0]),
    .read_index (in_tdata[15:8]),
    .wr0        (wr0),
    .wr1        (wr1),
    .rd         (rd),
    .meta       (meta)
  );

  scr_frame_store #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr0    (wr0),
    .wr1    (wr1),
    .rd     (rd),
    .even_q (even_q),
    .odd_q  (odd_q)
  );

  scr_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .take            (take),
    .meta            (meta),
    .even_q          (even_q),
    .odd_q           (odd_q),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (o_status),
    .out_frame_ready (o_ready),
    .out_len         (o_len),
    .out_data        (o_data)
  );

  assign out_tuser = o_status;
  assign out_tdata = {6'h00, o_data, o_len, o_ready};

endmodule

`default_nettype wire

// ----- hw/rtl/scr_checker.sv -----
// Port-level checks for the SLIP/CRC frame receiver, bound to the top level.
// Depends on scr_pkg and slip_crc_frame_receiver.
`default_nettype none

module scr_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [scr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [scr_pkg::STATUS_W-1:0]     out_tuser
);
  import scr_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // length is zero unless a frame is held
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[9:1] == '0)
    else $error("frame_length without held frame");

  // an accepted or busy-dropped frame means a frame is held
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK || out_tuser == ST_BUSY) |-> out_tdata[0])
    else $error("accept or busy status without held frame");

  // read data only comes from a held frame
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:10] != 8'h00 |-> out_tdata[0] && out_tuser == ST_NONE)
    else $error("read data without held frame");

endmodule

bind slip_crc_frame_receiver scr_checker u_scr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
